/* hdl/text_console_cell_writer_unit_assert.svh */
// Assertion macros used by the checker file.
// Both macros sample on clk and stay quiet while arst_n is low.
`ifndef TEXT_CONSOLE_CELL_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TCCW_ASSERT_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tccw: assertion failed");

// Next-cycle implication.
`define TCCW_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tccw: assertion failed");

`endif

/* hdl/tccw_pkg.sv */
package tccw_pkg;

	// Command opcodes
	typedef enum logic [2:0] {
		OP_PRINT  = 3'd0,
		OP_DRAW   = 3'd1,
		OP_SCROLL = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_READ   = 3'd4
	} opcode_t;

	// Register indexes on the APB port (paddr[2])
	localparam logic REG_COLS = 1'b0;
	localparam logic REG_ROWS = 1'b1;

	localparam logic [7:0] COLS_RESET   = 8'd80;
	localparam logic [6:0] ROWS_RESET   = 7'd25;
	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	// Command word
	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] char_code;
		logic [6:0] cell_col;
		logic [5:0] cell_row;
		logic [6:0] line_count;
	} cmd_t;

	// Result word
	typedef struct packed {
		logic [7:0] read_char;
		logic [6:0] cursor_col;
		logic [5:0] cursor_row;
		logic       changed;
	} res_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_WIPE,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_DRAIN,
		ST_CLEAR,
		ST_HOLD
	} state_t;

endpackage

/* hdl/text_console_cell_writer_unit.sv */
// Channel  Direction  Handshake               Payload
// cmd      in         cmd_valid / cmd_stall   tccw_pkg::cmd_t (one command word)
// res      out        res_valid / res_stall   tccw_pkg::res_t (one result word)
// apb      in         psel / penable / pready columns_in_use, rows_in_use
//
// Print, draw, read and unused opcodes are accepted, then executed.
// Scroll walks rows_in_use * MAX_COLS cells, one per cycle, reading and writing the cell memory.
// A print that runs off the bottom row adds that same one-row scroll walk.
// Clear sweeps all MAX_ROWS * 2**clog2(MAX_COLS) cells, one per cycle.
// After reset the same sweep runs once before the first command is taken.
// A waiting result sits in the output register; the next command is still taken.
module text_console_cell_writer_unit #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  tccw_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output tccw_pkg::res_t res
);
	import tccw_pkg::*;

	localparam int CW    = $clog2(MAX_COLS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = MAX_ROWS << CW;
	// wide enough for any count up to 256 and a sum of two row indexes
	localparam int CMP_W = 9;

	localparam logic [CMP_W-1:0] MAX_COLS_W = CMP_W'(MAX_COLS);
	localparam logic [CMP_W-1:0] MAX_ROWS_W = CMP_W'(MAX_ROWS);
	localparam logic [CW-1:0]    LAST_COL   = CW'(MAX_COLS - 1);
	localparam logic [AW-1:0]    LAST_ADDR  = AW'(DEPTH - 1);

	// config registers
	logic [7:0] cols_cfg_q;
	logic [6:0] rows_cfg_q;
	logic       cfg_wr;

	// control
	state_t state_q, state_d;
	cmd_t   item_q;
	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] cur_row_q;
	logic [AW-1:0] wc_q;
	logic [RW-1:0] sr_q;
	logic [CW-1:0] sc_q;
	logic [6:0]    sn_q;
	logic          wr_s1;
	logic [AW-1:0] wa_s1;
	logic          cp_s1;
	res_t res_q, res_d, res_out_q, out_src;
	logic res_valid_q;

	// strobes from the state machine
	logic load_out, use_d, start_scroll, scroll_step, out_free;

	// cell memory
	logic [7:0]    mem [DEPTH];
	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [7:0]    mem_wd, rd_q;

	// datapath
	logic [CMP_W-1:0] cols_w, rows_w;
	logic [CMP_W-1:0] cl_w, cc_w, col_next_w, row_next_w, src_w;
	logic [RW-1:0]    cl;
	logic [CW-1:0]    cc;
	logic             nl, wrap, bottom, p_scroll, in_rng, copy, scroll_last;
	logic [CW-1:0]    p_col;
	logic [RW-1:0]    p_row;
	logic [AW-1:0]    item_addr, cmd_addr, src_addr, dst_addr;

	// APB register file
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_cfg_q <= COLS_RESET;
			rows_cfg_q <= ROWS_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_COLS: cols_cfg_q <= pwdata[7:0];
				REG_ROWS: rows_cfg_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_COLS: prdata = 32'(cols_cfg_q);
			REG_ROWS: prdata = 32'(rows_cfg_q);
			default:  prdata = '0;
		endcase
	end

	// clamp the registers to the store size, and zero up to one
	always_comb begin
		if (cols_cfg_q == 8'd0)
			cols_w = CMP_W'(1);
		else if (CMP_W'(cols_cfg_q) > MAX_COLS_W)
			cols_w = MAX_COLS_W;
		else
			cols_w = CMP_W'(cols_cfg_q);
		if (rows_cfg_q == 7'd0)
			rows_w = CMP_W'(1);
		else if (CMP_W'(rows_cfg_q) > MAX_ROWS_W)
			rows_w = MAX_ROWS_W;
		else
			rows_w = CMP_W'(rows_cfg_q);
	end

	// print: saturate a stale cursor, then advance
	always_comb begin
		cl_w       = (CMP_W'(cur_row_q) >= rows_w) ? rows_w - CMP_W'(1) : CMP_W'(cur_row_q);
		cc_w       = (CMP_W'(cur_col_q) >= cols_w) ? cols_w - CMP_W'(1) : CMP_W'(cur_col_q);
		cl         = RW'(cl_w);
		cc         = CW'(cc_w);
		nl         = (item_q.char_code == NEWLINE_CODE);
		col_next_w = cc_w + CMP_W'(1);
		row_next_w = cl_w + CMP_W'(1);
		wrap       = nl || (col_next_w >= cols_w);
		bottom     = (row_next_w >= rows_w);
		p_scroll   = wrap && bottom;
		p_col      = wrap ? '0 : CW'(col_next_w);
		p_row      = (wrap && !bottom) ? RW'(row_next_w) : cl;
	end

	// draw / read addressing
	assign in_rng    = (CMP_W'(item_q.cell_col) < cols_w) && (CMP_W'(item_q.cell_row) < rows_w);
	assign item_addr = {RW'(item_q.cell_row), CW'(item_q.cell_col)};
	assign cmd_addr  = {RW'(cmd.cell_row), CW'(cmd.cell_col)};

	// scroll walk: row r takes row r+n, or zeros past the bottom
	always_comb begin
		src_w       = CMP_W'(sr_q) + CMP_W'(sn_q);
		copy        = (src_w < rows_w);
		src_addr    = {RW'(src_w), sc_q};
		dst_addr    = {sr_q, sc_q};
		scroll_last = (CMP_W'(sr_q) == rows_w - CMP_W'(1)) && (sc_q == LAST_COL);
	end

	// result of the item in execution
	always_comb begin
		res_d            = '0;
		res_d.cursor_col = 7'(cur_col_q);
		res_d.cursor_row = 6'(cur_row_q);
		case (item_q.opcode)
			OP_PRINT: begin
				res_d.cursor_col = 7'(p_col);
				res_d.cursor_row = 6'(p_row);
				res_d.changed    = 1'b1;
			end
			OP_DRAW:   res_d.changed = in_rng;
			OP_SCROLL: res_d.changed = 1'b1;
			OP_CLEAR:  res_d.changed = 1'b1;
			OP_READ:   res_d.read_char = in_rng ? rd_q : 8'd0;
			default: ;
		endcase
	end

	assign out_free = !res_valid_q || !res_stall;

	// next state, memory port and strobes
	always_comb begin
		state_d      = state_q;
		cmd_stall    = 1'b1;
		load_out     = 1'b0;
		use_d        = 1'b0;
		start_scroll = 1'b0;
		scroll_step  = 1'b0;
		mem_we       = wr_s1;
		mem_wa       = wa_s1;
		mem_wd       = cp_s1 ? rd_q : 8'd0;
		mem_ra       = src_addr;
		case (state_q)
			ST_WIPE: begin
				mem_we = 1'b1;
				mem_wa = wc_q;
				mem_wd = 8'd0;
				if (wc_q == LAST_ADDR)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cmd_stall = 1'b0;
				mem_ra    = cmd_addr;
				if (cmd_valid)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				use_d = 1'b1;
				case (item_q.opcode)
					OP_PRINT: begin
						mem_we = !nl;
						mem_wa = {cl, cc};
						mem_wd = item_q.char_code;
					end
					OP_DRAW: begin
						mem_we = in_rng;
						mem_wa = item_addr;
						mem_wd = item_q.char_code;
					end
					default: ;
				endcase
				if ((item_q.opcode == OP_PRINT) && p_scroll) begin
					start_scroll = 1'b1;
					state_d      = ST_SCROLL;
				end else if ((item_q.opcode == OP_SCROLL) && (item_q.line_count != 7'd0)) begin
					start_scroll = 1'b1;
					state_d      = ST_SCROLL;
				end else if (item_q.opcode == OP_CLEAR) begin
					state_d = ST_CLEAR;
				end else if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_SCROLL: begin
				scroll_step = 1'b1;
				if (scroll_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				// last copy write lands this cycle
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = wc_q;
				mem_wd = 8'd0;
				if (wc_q == LAST_ADDR) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_src = use_d ? res_d : res_q;

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WIPE;
			wc_q        <= '0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			sr_q        <= '0;
			sc_q        <= '0;
			wr_s1       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wr_s1   <= scroll_step;

			// sweep counter
			if ((state_q == ST_WIPE) || (state_q == ST_CLEAR))
				wc_q <= (wc_q == LAST_ADDR) ? '0 : wc_q + AW'(1);

			// cursor
			if ((state_q == ST_EXEC) && (item_q.opcode == OP_PRINT)) begin
				cur_col_q <= p_col;
				cur_row_q <= p_row;
			end

			// scroll walk position
			if (start_scroll) begin
				sr_q <= '0;
				sc_q <= '0;
			end else if (scroll_step) begin
				if (sc_q == LAST_COL) begin
					sc_q <= '0;
					sr_q <= sr_q + RW'(1);
				end else begin
					sc_q <= sc_q + CW'(1);
				end
			end

			// output register
			if (load_out)
				res_valid_q <= 1'b1;
			else if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall)
			item_q <= cmd;
		if (state_q == ST_EXEC)
			res_q <= res_d;
		if (start_scroll)
			sn_q <= (item_q.opcode == OP_PRINT) ? 7'd1 : item_q.line_count;
		if (scroll_step) begin
			wa_s1 <= dst_addr;
			cp_s1 <= copy;
		end
		if (load_out)
			res_out_q <= out_src;
	end

	assign res_valid = res_valid_q;
	assign res       = res_out_q;

endmodule

/* hdl/tccw_checker.sv */
`include "text_console_cell_writer_unit_assert.svh"

module tccw_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input logic           res_valid,
	input logic           res_stall,
	input tccw_pkg::res_t res
);
	import tccw_pkg::*;

	logic [1:0] pend_q;
	logic       acc, del;

	assign acc = cmd_valid && !cmd_stall;
	assign del = res_valid && !res_stall;

	// commands taken minus results delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + {1'b0, acc} - {1'b0, del};
	end

	`TCCW_ASSERT_NEXT(res_hold, res_valid && res_stall, res_valid && $stable(res))
	`TCCW_ASSERT_NEXT(one_cmd_in_flight, acc, cmd_stall)
	`TCCW_ASSERT_IMPLY(read_keeps_screen, res_valid && (res.read_char != 8'd0), !res.changed)
	`TCCW_ASSERT_IMPLY(no_result_without_cmd, res_valid, pend_q != 2'd0)

endmodule

bind text_console_cell_writer_unit tccw_checker u_tccw_checker (.*);

/* test/text_console_cell_writer_unit_test.sv */
`timescale 1ns / 1ps

module text_console_cell_writer_unit_test;
	import tccw_pkg::*;

	localparam int CELL_COLS = 128;
	localparam int CELL_ROWS = 64;
	// longest walk of the block (full clear sweep) plus margin
	localparam int SETTLE_CYCLES = CELL_ROWS * CELL_COLS + 32;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int RX_LONG_HOLD = 400;
	localparam logic [2:0] ADDR_COLS = {REG_COLS, 2'b00};
	localparam logic [2:0] ADDR_ROWS = {REG_ROWS, 2'b00};
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	text_console_cell_writer_unit #(
		.MAX_COLS(CELL_COLS),
		.MAX_ROWS(CELL_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always #4 clk = ~clk;

	// Shadow console state
	logic [7:0] screen [0:CELL_ROWS*CELL_COLS-1];
	int unsigned cur_col;
	int unsigned cur_row;
	logic [7:0] cols_reg;
	logic [6:0] rows_reg;

	cmd_t cmd_pending[$];
	res_t console_due[$];
	int n_issued = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_by_op [0:7];
	int n_bottom_scrolls = 0;
	int n_nonblank_reads = 0;
	bit calm = 1'b0;
	bit cmd_taken = 1'b0;
	int tx_gap = 0;
	int rx_gap = 0;
	int rx_hold = 0;
	bit rx_hold_done = 1'b0;
	int cycle_count = 0;

	function automatic int unsigned visible_cols();
		if (cols_reg < 1) return 1;
		if (cols_reg > CELL_COLS) return CELL_COLS;
		return cols_reg;
	endfunction

	function automatic int unsigned visible_rows();
		if (rows_reg < 1) return 1;
		if (rows_reg > CELL_ROWS) return CELL_ROWS;
		return rows_reg;
	endfunction

	// Move the screen rows up by n; vacated rows come back blank
	function automatic void shift_up(int unsigned n, int unsigned nrow);
		for (int unsigned r = 0; r < nrow; r++) begin
			for (int unsigned k = 0; k < CELL_COLS; k++) begin
				if (n < nrow && r + n < nrow)
					screen[r*CELL_COLS+k] = screen[(r+n)*CELL_COLS+k];
				else
					screen[r*CELL_COLS+k] = 8'h00;
			end
		end
	endfunction

	function automatic void line_feed(int unsigned nrow);
		cur_col = 0;
		cur_row++;
		if (cur_row >= nrow) begin
			cur_row = nrow - 1;
			shift_up(1, nrow);
			n_bottom_scrolls++;
		end
	endfunction

	// Apply one command word to the shadow console, return the result word it gives
	function automatic res_t console_apply(cmd_t c);
		res_t r;
		int unsigned ncol;
		int unsigned nrow;
		ncol = visible_cols();
		nrow = visible_rows();
		r = '0;
		case (c.opcode)
			OP_PRINT: begin
				// cursor left off screen by a register change snaps back first
				if (cur_row >= nrow) cur_row = nrow - 1;
				if (cur_col >= ncol) cur_col = ncol - 1;
				if (c.char_code == NEWLINE_CODE) begin
					line_feed(nrow);
				end else begin
					screen[cur_row*CELL_COLS+cur_col] = c.char_code;
					cur_col++;
					if (cur_col >= ncol) line_feed(nrow);
				end
				r.changed = 1'b1;
			end
			OP_DRAW: begin
				if (c.cell_col < ncol && c.cell_row < nrow) begin
					screen[c.cell_row*CELL_COLS+c.cell_col] = c.char_code;
					r.changed = 1'b1;
				end
			end
			OP_SCROLL: begin
				if (c.line_count != 0) shift_up(c.line_count, nrow);
				r.changed = 1'b1;
			end
			OP_CLEAR: begin
				foreach (screen[i]) screen[i] = 8'h00;
				r.changed = 1'b1;
			end
			OP_READ: begin
				if (c.cell_col < ncol && c.cell_row < nrow) begin
					r.read_char = screen[c.cell_row*CELL_COLS+c.cell_col];
					if (r.read_char != 0) n_nonblank_reads++;
				end
			end
			default: begin
			end
		endcase
		r.cursor_col = cur_col[6:0];
		r.cursor_row = cur_row[5:0];
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: word %0d %s expected %0d got %0d", $time, n_checked, name, want, got);
			n_errors++;
		end
	endfunction

	function automatic void push_cmd(logic [2:0] op, logic [7:0] code, logic [6:0] col,
			logic [5:0] row, logic [6:0] count);
		cmd_t w;
		w.opcode = op;
		w.char_code = code;
		w.cell_col = col;
		w.cell_row = row;
		w.line_count = count;
		cmd_pending.push_back(w);
		n_issued++;
	endfunction

	// Random command; weights in per mille, positions mostly on the visible screen
	function automatic cmd_t random_word(int scroll_pm, int clear_pm);
		cmd_t w;
		int unsigned pick;
		int unsigned ncol;
		int unsigned nrow;
		int base;
		ncol = visible_cols();
		nrow = visible_rows();
		base = clear_pm + scroll_pm + 15;
		w.opcode = OP_PRINT;
		w.char_code = 8'($urandom_range(0, 255));
		w.cell_col = 7'($urandom_range(0, 127));
		w.cell_row = 6'($urandom_range(0, 63));
		w.line_count = 7'($urandom_range(0, 127));
		pick = $urandom_range(0, 999);
		if (pick < clear_pm) begin
			w.opcode = OP_CLEAR;
		end else if (pick < clear_pm + scroll_pm) begin
			w.opcode = OP_SCROLL;
			if ($urandom_range(0, 1) != 0)
				w.line_count = 7'($urandom_range(0, nrow + 1 > 127 ? 127 : nrow + 1));
		end else if (pick < base) begin
			w.opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		end else if (pick < base + 350) begin
			w.opcode = (pick < base + 150) ? OP_DRAW : OP_READ;
			if ($urandom_range(0, 4) != 0) begin
				w.cell_col = 7'($urandom_range(0, ncol - 1));
				w.cell_row = 6'($urandom_range(0, nrow - 1));
			end
		end else if ($urandom_range(0, 7) == 0) begin
			w.char_code = NEWLINE_CODE;
		end
		return w;
	endfunction

	// Accept side: predict each command word as it is taken
	always @(posedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall) begin
			console_due.push_back(console_apply(cmd));
			n_by_op[cmd.opcode]++;
			n_accepted++;
			cmd_taken <= 1'b1;
		end else begin
			cmd_taken <= 1'b0;
		end
	end

	// Command driver with random idle bursts
	always @(negedge clk) begin
		if (!cmd_valid || cmd_taken) begin
			if (tx_gap > 0) begin
				tx_gap--;
				cmd_valid <= 1'b0;
			end else if (cmd_pending.size() == 0) begin
				cmd_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				tx_gap = $urandom_range(1, 17) - 1;
				cmd_valid <= 1'b0;
			end else begin
				cmd <= cmd_pending.pop_front();
				cmd_valid <= 1'b1;
			end
		end
	end

	// Result stall: random bursts plus one long hold to back the block up
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			res_stall <= 1'b1;
		end else if (!rx_hold_done && n_checked >= 100) begin
			rx_hold_done = 1'b1;
			rx_hold = RX_LONG_HOLD - 1;
			res_stall <= 1'b1;
		end else if (rx_gap > 0) begin
			rx_gap--;
			res_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			rx_gap = $urandom_range(1, 17) - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (console_due.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, res);
				n_errors++;
			end else begin
				res_t want;
				want = console_due.pop_front();
				check_field("read_char", want.read_char, res.read_char);
				check_field("cursor_col", want.cursor_col, res.cursor_col);
				check_field("cursor_row", want.cursor_row, res.cursor_row);
				check_field("changed", want.changed, res.changed);
			end
			n_checked++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d of %0d words checked", $time, n_checked, n_issued);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic wait_drained();
		while (cmd_pending.size() != 0 || n_accepted != n_issued || n_checked != n_accepted)
			@(negedge clk);
	endtask

	// Register write followed by a readback
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
		logic [31:0] got;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_COLS)
			cols_reg = value[7:0];
		else
			rows_reg = value[6:0];
		if (got !== value) begin
			$display("%0t: register %0d readback expected %0d got %0d", $time, addr, value, got);
			n_errors++;
		end
	endtask

	task automatic run_phase(input logic [7:0] cols, input logic [6:0] rows, input int items,
			input int scroll_pm, input int clear_pm, input bit quiet, input bit pause_mid);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		reg_write(ADDR_COLS, {24'd0, cols});
		reg_write(ADDR_ROWS, {25'd0, rows});
		calm = quiet;
		for (int i = 0; i < items; i++) begin
			// sender holds off mid-phase until every result is back
			if (pause_mid && i == items / 2) wait_drained();
			cmd_pending.push_back(random_word(scroll_pm, clear_pm));
			n_issued++;
		end
	endtask

	initial begin
		foreach (screen[i]) screen[i] = 8'h00;
		foreach (n_by_op[i]) n_by_op[i] = 0;
		cur_col = 0;
		cur_row = 0;
		cols_reg = COLS_RESET;
		rows_reg = ROWS_RESET;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed words on the reset-size screen
		push_cmd(OP_READ, 8'h00, 7'd0, 6'd0, 7'd0);
		push_cmd(OP_PRINT, 8'hFF, 7'd0, 6'd0, 7'd0);
		push_cmd(OP_PRINT, 8'h00, 7'd127, 6'd63, 7'd127);
		push_cmd(OP_PRINT, NEWLINE_CODE, 7'd0, 6'd0, 7'd0);
		push_cmd(OP_DRAW, 8'h5A, 7'd79, 6'd24, 7'd0);
		push_cmd(OP_DRAW, 8'h11, 7'd80, 6'd0, 7'd0);
		push_cmd(OP_DRAW, 8'h22, 7'd127, 6'd63, 7'd0);
		push_cmd(OP_READ, 8'h00, 7'd79, 6'd24, 7'd0);
		push_cmd(OP_READ, 8'hFF, 7'd127, 6'd63, 7'd127);
		push_cmd(OP_READ, 8'h00, 7'd0, 6'd0, 7'd0);
		push_cmd(OP_SCROLL, 8'h00, 7'd0, 6'd0, 7'd0);
		push_cmd(OP_SCROLL, 8'h00, 7'd0, 6'd0, 7'd1);
		push_cmd(OP_READ, 8'h00, 7'd79, 6'd23, 7'd0);
		push_cmd(OP_SCROLL, 8'h00, 7'd0, 6'd0, 7'd64);
		push_cmd(OP_READ, 8'h00, 7'd79, 6'd23, 7'd0);
		for (int k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++)
			push_cmd(3'(k), 8'hFF, 7'd127, 6'd63, 7'd127);
		push_cmd(OP_DRAW, 8'hAA, 7'd0, 6'd0, 7'd0);
		push_cmd(OP_CLEAR, 8'h00, 7'd0, 6'd0, 7'd0);
		push_cmd(OP_READ, 8'h00, 7'd0, 6'd0, 7'd0);
		push_cmd(OP_SCROLL, 8'h00, 7'd0, 6'd0, 7'd127);

		// Random phases over a spread of screen sizes, out-of-range values included
		run_phase(8'd8, 7'd4, 400, 40, 10, 1'b0, 1'b0);
		run_phase(8'd1, 7'd1, 250, 40, 10, 1'b0, 1'b0);
		run_phase(8'd0, 7'd0, 100, 40, 10, 1'b0, 1'b0);
		run_phase(8'd255, 7'd127, 60, 15, 15, 1'b0, 1'b0);
		run_phase(8'd128, 7'd64, 60, 15, 15, 1'b1, 1'b0);
		run_phase(8'd3, 7'd2, 300, 40, 10, 1'b0, 1'b0);
		run_phase(8'd17, 7'd9, 300, 40, 10, 1'b0, 1'b1);
		run_phase(8'd40, 7'd12, 250, 40, 10, 1'b0, 1'b0);
		run_phase(8'd5, 7'd3, 250, 40, 10, 1'b1, 1'b0);

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (console_due.size() != 0) begin
			$display("%0t: %0d result words never arrived", $time, console_due.size());
			n_errors++;
		end
		$display("covered %0d words: %0d print, %0d draw, %0d scroll, %0d clear, %0d read, %0d spare",
			n_checked, n_by_op[OP_PRINT], n_by_op[OP_DRAW], n_by_op[OP_SCROLL],
			n_by_op[OP_CLEAR], n_by_op[OP_READ],
			n_by_op[5] + n_by_op[6] + n_by_op[7]);
		$display("%0d bottom-row scroll-offs, %0d non-blank reads, 9 screen sizes, %0d errors",
			n_bottom_scrolls, n_nonblank_reads, n_errors);
		if (n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
